>>> src/keyword_substitution_cipher_defines.svh
// Assertion macros for the keyword substitution cipher.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define KSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define KSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ksc_pkg.sv
// Shared types and constants of the keyword substitution cipher.
package ksc_pkg;

    localparam int ALPHA      = 26;
    localparam int LETTER_W   = 5;
    localparam int KEY_SLOTS  = 12;
    localparam int KEY_IDX_W  = 4;
    localparam int KEY_W      = KEY_SLOTS * LETTER_W;
    localparam int LEN_W      = 4;
    localparam int SHIFT_W    = 5;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KEY_W;

    localparam logic [LETTER_W-1:0] ALPHA_CODE = LETTER_W'(ALPHA);
    localparam logic [CHAR_W-1:0]   CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0]   CHAR_Z     = 8'h5A;

    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LETTERS = 2'd0,
        CFG_KEY_LENGTH  = 2'd1,
        CFG_SHIFT_DIST  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                we;
        logic [LETTER_W-1:0] addr;
        logic [LETTER_W-1:0] data;
    } tbl_wr_t;

endpackage

>>> src/ksc_build_seq.sv
// Microcoded sequencer that builds the substitution table from the key registers.
module ksc_build_seq #(
    parameter int MAX_KEY_LETTERS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ksc_pkg::KEY_W-1:0]        key_letters,
    input  logic [ksc_pkg::LEN_W-1:0]        key_length,
    input  logic [ksc_pkg::SHIFT_W-1:0]      shift_distance,
    output ksc_pkg::tbl_wr_t                 tbl_wr,
    output logic                             done
);
    import ksc_pkg::*;

    localparam int KIDX_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;
    localparam int NK_W   = $clog2(MAX_KEY_LETTERS + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEY_LETTERS);

    typedef enum logic [2:0] {
        UOP_SCAN_KEY,
        UOP_CLAMP,
        UOP_PICK,
        UOP_EMIT_HIGH,
        UOP_EMIT_KEY,
        UOP_EMIT_REST,
        UOP_ACK
    } uop_t;

    typedef enum logic [1:0] {
        LIM_LEN,
        LIM_NKEY,
        LIM_ALPHA,
        LIM_PICK
    } lim_t;

    localparam logic [2:0] STEP_SCAN      = 3'd0;
    localparam logic [2:0] STEP_CLAMP     = 3'd1;
    localparam logic [2:0] STEP_PICK      = 3'd2;
    localparam logic [2:0] STEP_EMIT_HIGH = 3'd3;
    localparam logic [2:0] STEP_EMIT_KEY  = 3'd4;
    localparam logic [2:0] STEP_EMIT_REST = 3'd5;
    localparam logic [2:0] STEP_ACK       = 3'd6;

    typedef struct packed {
        uop_t       uop;
        lim_t       lim;
        logic       from_top;
        logic [2:0] next;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [2:0] step);
        ucode_t w;
        unique case (step)
            STEP_SCAN:      w = '{uop: UOP_SCAN_KEY,  lim: LIM_LEN,   from_top: 1'b0,
                                  next: STEP_CLAMP};
            STEP_CLAMP:     w = '{uop: UOP_CLAMP,     lim: LIM_PICK,  from_top: 1'b0,
                                  next: STEP_PICK};
            STEP_PICK:      w = '{uop: UOP_PICK,      lim: LIM_PICK,  from_top: 1'b1,
                                  next: STEP_EMIT_HIGH};
            STEP_EMIT_HIGH: w = '{uop: UOP_EMIT_HIGH, lim: LIM_ALPHA, from_top: 1'b0,
                                  next: STEP_EMIT_KEY};
            STEP_EMIT_KEY:  w = '{uop: UOP_EMIT_KEY,  lim: LIM_NKEY,  from_top: 1'b0,
                                  next: STEP_EMIT_REST};
            STEP_EMIT_REST: w = '{uop: UOP_EMIT_REST, lim: LIM_ALPHA, from_top: 1'b0,
                                  next: STEP_ACK};
            default:        w = '{uop: UOP_ACK,       lim: LIM_PICK,  from_top: 1'b0,
                                  next: STEP_SCAN};
        endcase
        return w;
    endfunction

    logic                running_reg, running_next;
    logic [2:0]          pc_reg, pc_next;
    logic [LETTER_W-1:0] cnt_reg, cnt_next;
    logic [ALPHA-1:0]    in_key_reg, in_key_next;
    logic [ALPHA-1:0]    high_reg, high_next;
    logic [NK_W-1:0]     nkey_reg, nkey_next;
    logic [LETTER_W-1:0] picked_reg, picked_next;
    logic [LETTER_W-1:0] d_reg, d_next;
    logic [LETTER_W-1:0] pos_reg, pos_next;
    logic [LETTER_W-1:0] keys_reg [MAX_KEY_LETTERS];
    logic [LETTER_W-1:0] keys_next [MAX_KEY_LETTERS];

    logic [LETTER_W-1:0] key_arr [KEY_SLOTS];
    logic [LEN_W-1:0]    len;
    ucode_t              uw, nw;
    logic [LETTER_W-1:0] limit;
    logic [LETTER_W-1:0] key_c, pick_c, room;
    logic                single, active, step_exit;

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            key_arr[i] = key_letters[i*LETTER_W +: LETTER_W];
        end
    end

    assign len    = (key_length > MAX_LEN) ? MAX_LEN : key_length;
    assign key_c  = key_arr[cnt_reg[KEY_IDX_W-1:0]];
    assign pick_c = cnt_reg - 5'd1;
    assign room   = ALPHA_CODE - LETTER_W'(nkey_reg);

    always_comb begin
        uw = ucode_rom(pc_reg);
        nw = ucode_rom(uw.next);

        unique case (uw.lim)
            LIM_LEN:   limit = LETTER_W'(len);
            LIM_NKEY:  limit = LETTER_W'(nkey_reg);
            LIM_ALPHA: limit = ALPHA_CODE;
            default:   limit = '0;
        endcase

        single = (uw.uop == UOP_CLAMP) || (uw.uop == UOP_ACK);
        if (uw.uop == UOP_PICK) begin
            active = (cnt_reg != '0) && (picked_reg < d_reg);
        end else if (single) begin
            active = 1'b1;
        end else begin
            active = cnt_reg < limit;
        end
        step_exit = single || !active;

        running_next = running_reg;
        pc_next      = pc_reg;
        cnt_next     = cnt_reg;
        in_key_next  = in_key_reg;
        high_next    = high_reg;
        nkey_next    = nkey_reg;
        picked_next  = picked_reg;
        d_next       = d_reg;
        pos_next     = pos_reg;
        keys_next    = keys_reg;
        tbl_wr       = '0;
        done         = 1'b0;

        if (running_reg) begin
            if (active) begin
                case (uw.uop)
                    UOP_SCAN_KEY: begin
                        if (key_c < ALPHA_CODE) begin
                            if (!in_key_reg[key_c]) begin
                                in_key_next[key_c]               = 1'b1;
                                keys_next[nkey_reg[KIDX_W-1:0]]  = key_c;
                                nkey_next                        = nkey_reg + 1'b1;
                            end
                        end
                        cnt_next = cnt_reg + 5'd1;
                    end
                    UOP_CLAMP: begin
                        d_next = (LETTER_W'(shift_distance) > room) ? room
                                                                    : LETTER_W'(shift_distance);
                    end
                    UOP_PICK: begin
                        if (!in_key_reg[pick_c]) begin
                            high_next[pick_c] = 1'b1;
                            picked_next       = picked_reg + 5'd1;
                        end
                        cnt_next = cnt_reg - 5'd1;
                    end
                    UOP_EMIT_HIGH: begin
                        if (high_reg[cnt_reg]) begin
                            tbl_wr   = '{we: 1'b1, addr: pos_reg, data: cnt_reg};
                            pos_next = pos_reg + 5'd1;
                        end
                        cnt_next = cnt_reg + 5'd1;
                    end
                    UOP_EMIT_KEY: begin
                        tbl_wr   = '{we: 1'b1, addr: pos_reg,
                                     data: keys_reg[cnt_reg[KIDX_W-1:0]]};
                        pos_next = pos_reg + 5'd1;
                        cnt_next = cnt_reg + 5'd1;
                    end
                    UOP_EMIT_REST: begin
                        if (!(high_reg[cnt_reg] || in_key_reg[cnt_reg])) begin
                            tbl_wr   = '{we: 1'b1, addr: pos_reg, data: cnt_reg};
                            pos_next = pos_reg + 5'd1;
                        end
                        cnt_next = cnt_reg + 5'd1;
                    end
                    default: begin
                        done         = 1'b1;
                        running_next = 1'b0;
                    end
                endcase
            end
            if (step_exit) begin
                pc_next  = uw.next;
                cnt_next = nw.from_top ? ALPHA_CODE : '0;
            end
        end else if (start) begin
            running_next = 1'b1;
            pc_next      = STEP_SCAN;
            cnt_next     = '0;
            in_key_next  = '0;
            high_next    = '0;
            nkey_next    = '0;
            picked_next  = '0;
            pos_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pc_reg      <= STEP_SCAN;
        end else begin
            running_reg <= running_next;
            pc_reg      <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        in_key_reg <= in_key_next;
        high_reg   <= high_next;
        nkey_reg   <= nkey_next;
        picked_reg <= picked_next;
        d_reg      <= d_next;
        pos_reg    <= pos_next;
        keys_reg   <= keys_next;
    end

endmodule

>>> src/keyword_substitution_cipher.sv
// Keyword substitution cipher: an encode beat (s_tuser = 1) maps an uppercase ASCII letter
// through a 26-entry table and passes any other byte; its result appears in the next cycle and
// encodes stream at one beat per cycle while m_tready stays high; a result that waits on
// m_tready holds s_tready low until it is taken.
// A build beat (s_tuser = 0) rebuilds the table from the key registers with a microcoded
// sequencer that visits one letter or key slot per cycle through the single table write port;
// it holds s_tready low while it scans the key letters, picks the high letters from the top
// and writes the table, and then returns one
// acknowledge beat with m_tuser = 1 and m_tdata = 0.
// The table resets to identity. Write the configuration registers only while idle.
`include "keyword_substitution_cipher_defines.svh"

module keyword_substitution_cipher #(
    parameter int MAX_KEY_LETTERS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ksc_pkg::CHAR_W-1:0]           s_tdata,   // in_char[7:0]
    input  logic [0:0]                           s_tuser,   // op[0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ksc_pkg::CHAR_W-1:0]           m_tdata,   // out_char[7:0]
    output logic [0:0]                           m_tuser,   // build_ack[0]
    input  logic                                 cfg_wr_en,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ksc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import ksc_pkg::*;

    logic [KEY_W-1:0]    key_letters_reg;
    logic [LEN_W-1:0]    key_length_reg;
    logic [SHIFT_W-1:0]  shift_dist_reg;
    logic [LETTER_W-1:0] sub_tbl_reg [ALPHA];

    logic                busy_reg, busy_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]   m_tdata_reg;
    logic                m_tuser_reg;

    logic                s_accept, build_start, enc_accept;
    logic                is_letter;
    logic [LETTER_W-1:0] tbl_idx;
    logic [CHAR_W-1:0]   enc_char;
    tbl_wr_t             tbl_wr;
    logic                seq_done;

    ksc_build_seq #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_build_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (build_start),
        .key_letters    (key_letters_reg),
        .key_length     (key_length_reg),
        .shift_distance (shift_dist_reg),
        .tbl_wr         (tbl_wr),
        .done           (seq_done)
    );

    assign s_tready    = !busy_reg && (!m_tvalid_reg || m_tready);
    assign s_accept    = s_tvalid && s_tready;
    assign build_start = s_accept && (s_tuser[0] == OP_BUILD);
    assign enc_accept  = s_accept && (s_tuser[0] == OP_ENCODE);

    assign is_letter = (s_tdata >= CHAR_A) && (s_tdata <= CHAR_Z);
    assign tbl_idx   = LETTER_W'(s_tdata - CHAR_A);
    assign enc_char  = is_letter ? (CHAR_A + CHAR_W'(sub_tbl_reg[tbl_idx])) : s_tdata;

    always_comb begin
        busy_next = busy_reg;
        if (build_start) begin
            busy_next = 1'b1;
        end else if (seq_done) begin
            busy_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (seq_done || enc_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            key_letters_reg <= '0;
            key_length_reg  <= '0;
            shift_dist_reg  <= '0;
            for (int i = 0; i < ALPHA; i++) begin
                sub_tbl_reg[i] <= LETTER_W'(i);
            end
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_LETTERS: key_letters_reg <= cfg_wdata[KEY_W-1:0];
                    CFG_KEY_LENGTH:  key_length_reg  <= cfg_wdata[LEN_W-1:0];
                    CFG_SHIFT_DIST:  shift_dist_reg  <= cfg_wdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (tbl_wr.we) begin
                sub_tbl_reg[tbl_wr.addr] <= tbl_wr.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_done) begin
            m_tdata_reg <= '0;
            m_tuser_reg <= 1'b1;
        end else if (enc_accept) begin
            m_tdata_reg <= enc_char;
            m_tuser_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `KSC_ASSERT_NEXT(a_build_stalls, build_start, busy_reg && !m_tvalid_reg, "build did not stall")
    `KSC_ASSERT_NEXT(a_enc_result, enc_accept, m_tvalid_reg && !m_tuser_reg, "encode lost")
    `KSC_ASSERT_IMPL(a_wr_in_build, tbl_wr.we, busy_reg, "table write outside build")
    `KSC_ASSERT_NEXT(a_build_ack, seq_done, m_tvalid_reg && m_tuser_reg && m_tdata_reg == '0, "bad ack")

endmodule

>>> verif/keyword_substitution_cipher_checker.sv
`timescale 1ns / 1ps
// Checker for the keyword substitution cipher: predicts each result and compares the output beats.
module keyword_substitution_cipher_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ksc_pkg::CHAR_W-1:0]     s_tdata,   // in_char[7:0]
    input  logic [0:0]                     s_tuser,   // op[0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ksc_pkg::CHAR_W-1:0]     m_tdata,   // out_char[7:0]
    input  logic [0:0]                     m_tuser,   // build_ack[0]
    input  logic                           cfg_wr_en,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ksc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             pending
);
    import ksc_pkg::*;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [ALPHA-1:0][LETTER_W-1:0] letter_map_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              build_ack;
    } cipher_out_t;

    logic [KEY_W-1:0]   key_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [SHIFT_W-1:0] shift_reg;
    letter_map_t        sub_map;
    cipher_out_t        awaited_outputs [$];
    int                 mismatches = 0;
    int                 results_seen = 0;

    assign errors = mismatches;

    function automatic letter_map_t make_substitution_map(input logic [KEY_W-1:0] key,
                                                          input logic [LEN_W-1:0] len,
                                                          input logic [SHIFT_W-1:0] shift);
        letter_map_t      map;
        letter_map_t      key_order;
        logic [ALPHA-1:0] key_mask = '0;
        logic [ALPHA-1:0] high_mask = '0;
        letter_t          c;
        int               used;
        int               n_key = 0;
        int               shift_cnt;
        int               picked = 0;
        int               slot = 0;
        used = (int'(len) > KEY_SLOTS) ? KEY_SLOTS : int'(len);
        for (int i = 0; i < used; i++) begin
            c = key[LETTER_W*i +: LETTER_W];
            if (c < ALPHA_CODE && !key_mask[c]) begin
                key_mask[c] = 1'b1;
                key_order[n_key] = c;
                n_key++;
            end
        end
        shift_cnt = (int'(shift) > ALPHA - n_key) ? ALPHA - n_key : int'(shift);
        for (int i = ALPHA - 1; i >= 0 && picked < shift_cnt; i--) begin
            if (!key_mask[i]) begin
                high_mask[i] = 1'b1;
                picked++;
            end
        end
        for (int i = 0; i < ALPHA; i++) begin
            if (high_mask[i]) begin
                map[slot] = letter_t'(i);
                slot++;
            end
        end
        for (int i = 0; i < n_key; i++) begin
            map[slot] = key_order[i];
            slot++;
        end
        for (int i = 0; i < ALPHA; i++) begin
            if (!high_mask[i] && !key_mask[i]) begin
                map[slot] = letter_t'(i);
                slot++;
            end
        end
        return map;
    endfunction

    function automatic logic [CHAR_W-1:0] encode_byte(input letter_map_t map,
                                                      input logic [CHAR_W-1:0] ch);
        if (ch >= CHAR_A && ch <= CHAR_Z) begin
            return CHAR_A + CHAR_W'(map[ch - CHAR_A]);
        end
        return ch;
    endfunction

    task automatic note_mismatch(input string what, input cipher_out_t want);
        if (mismatches < 10) begin
            $display("[%0t] result %0d %s: expected char %02h ack %0d, got char %02h ack %0d",
                     $time, results_seen, what, want.out_char, want.build_ack,
                     m_tdata, m_tuser[0]);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        cipher_out_t want;
        if (!aresetn) begin
            key_reg   = '0;
            len_reg   = '0;
            shift_reg = '0;
            for (int i = 0; i < ALPHA; i++) begin
                sub_map[i] = letter_t'(i);
            end
            awaited_outputs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_outputs.size() == 0) begin
                    note_mismatch("unexpected", '0);
                end else begin
                    want = awaited_outputs.pop_front();
                    if (m_tdata !== want.out_char || m_tuser[0] !== want.build_ack) begin
                        note_mismatch("mismatch", want);
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_BUILD) begin
                    sub_map = make_substitution_map(key_reg, len_reg, shift_reg);
                    awaited_outputs.push_back('{out_char: '0, build_ack: 1'b1});
                end else begin
                    awaited_outputs.push_back('{out_char: encode_byte(sub_map, s_tdata),
                                                build_ack: 1'b0});
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_LETTERS: key_reg = cfg_wdata[KEY_W-1:0];
                    CFG_KEY_LENGTH: len_reg = cfg_wdata[LEN_W-1:0];
                    CFG_SHIFT_DIST: shift_reg = cfg_wdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= awaited_outputs.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench of the keyword substitution cipher: clock, stimulus, watchdog and verdict.
module testbench;
    import ksc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_BEATS = 1850;
    localparam int TAIL_BEATS   = 200;
    localparam int DRAIN_CYCLES = 150;

    typedef enum int {
        KEY_ANY,
        KEY_DISTINCT,
        KEY_REPEATS,
        KEY_MOSTLY_LETTERS
    } key_style_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata;   // in_char[7:0]
    logic [0:0]            s_tuser;   // op[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CHAR_W-1:0]     m_tdata;   // out_char[7:0]
    logic [0:0]            m_tuser;   // build_ack[0]
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int errors;
    int pending;
    int beats_sent = 0;
    int quiet_cycles = 0;
    bit bursts_on = 1'b1;

    keyword_substitution_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    keyword_substitution_cipher_checker cipher_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (bursts_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [KEY_W-1:0] random_key(input key_style_t style);
        logic [KEY_W-1:0]    key;
        logic [ALPHA-1:0]    taken = '0;
        logic [LETTER_W-1:0] c;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            case (style)
                KEY_ANY: c = LETTER_W'($urandom_range(0, 31));
                KEY_DISTINCT: begin
                    do c = LETTER_W'($urandom_range(0, ALPHA - 1)); while (taken[c]);
                    taken[c] = 1'b1;
                end
                KEY_REPEATS: c = LETTER_W'($urandom_range(20, 25));
                default: c = ($urandom_range(0, 9) == 0) ? LETTER_W'($urandom_range(ALPHA, 31))
                                                          : LETTER_W'($urandom_range(0, ALPHA - 1));
            endcase
            key[LETTER_W*i +: LETTER_W] = c;
        end
        return key;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        if ($urandom_range(0, 9) < 7) begin
            return CHAR_A + CHAR_W'($urandom_range(0, ALPHA - 1));
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_key(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len,
                            input logic [SHIFT_W-1:0] shift);
        logic [CFG_DATA_W-1:0] noise;
        noise = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
        drain();
        write_reg(CFG_KEY_LETTERS, key);
        write_reg(CFG_KEY_LENGTH, {noise[CFG_DATA_W-1:LEN_W], len});
        write_reg(CFG_SHIFT_DIST, {noise[CFG_DATA_W-1:SHIFT_W], shift});
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int         phase;
        int         run_len;
        key_style_t style;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ENCODE;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // identity table out of reset, letter bounds and non-letter bytes
        send_item(OP_ENCODE, CHAR_A);
        send_item(OP_ENCODE, CHAR_Z);
        send_item(OP_ENCODE, 8'h40);
        send_item(OP_ENCODE, 8'h5B);
        send_item(OP_ENCODE, 8'h00);
        send_item(OP_ENCODE, 8'hFF);
        send_item(OP_ENCODE, 8'h61);
        send_item(OP_BUILD, 8'hFF);
        send_item(OP_ENCODE, 8'h4D);

        // over-long key with repeats and bad letter codes, distance beyond range
        load_key({5'd0, 5'd25, 5'd26, 5'd3, 5'd17, 5'd14, 5'd22, 5'd31, 5'd10, 5'd24,
                  5'd4, 5'd10}, 4'd15, 5'd31);
        send_item(OP_BUILD, 8'h00);
        send_item(OP_ENCODE, CHAR_A);
        send_item(OP_ENCODE, CHAR_Z);
        send_item(OP_ENCODE, 8'h51);

        // full key of distinct letters, distance clamped to the 14 letters left
        load_key(random_key(KEY_DISTINCT), 4'd12, 5'd25);
        send_item(OP_BUILD, 8'h41);
        send_item(OP_ENCODE, CHAR_A);
        send_item(OP_ENCODE, CHAR_Z);

        // empty key; the spare register index must change nothing
        load_key({KEY_W{1'b1}}, 4'd0, 5'd0);
        drain();
        write_reg(CFG_SPARE, {CFG_DATA_W{1'b1}});
        cfg_wr_en <= 1'b0;
        send_item(OP_BUILD, 8'h00);
        send_item(OP_ENCODE, CHAR_A);
        send_item(OP_ENCODE, CHAR_Z);

        // empty key with a rotation of the high letters
        load_key('0, 4'd0, 5'd5);
        send_item(OP_BUILD, 8'h00);
        send_item(OP_ENCODE, CHAR_A);
        send_item(OP_ENCODE, 8'h59);

        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            if (beats_sent >= TARGET_BEATS - TAIL_BEATS) begin
                bursts_on = 1'b0;
            end
            case (phase % 6)
                0: load_key(random_key(KEY_DISTINCT), 4'd12, 5'd25);
                1: load_key(random_key(KEY_ANY), 4'd0, 5'd0);
                2: load_key(random_key(KEY_REPEATS), LEN_W'($urandom_range(0, 15)), 5'd31);
                default: begin
                    style = key_style_t'($urandom_range(0, 3));
                    load_key(random_key(style), LEN_W'($urandom_range(0, 15)),
                             SHIFT_W'($urandom_range(0, 31)));
                end
            endcase
            send_item(OP_BUILD, random_char());
            run_len = $urandom_range(20, 70);
            repeat (run_len) begin
                send_item(($urandom_range(0, 24) == 0) ? OP_BUILD : OP_ENCODE, random_char());
            end
            phase++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
